>>> design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> design/ycc_pkg.sv
// Shared constants, coefficient helpers and clipping for the RGB to YCbCr 4:2:0 converter.
package ycc_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int NUM_PIX = 4;
   localparam int NUM_CH  = 3;
   localparam int CH_R    = 0;
   localparam int CH_G    = 1;
   localparam int CH_B    = 2;

   localparam int PIX_W   = 24;
   localparam int COMP_W  = 8;
   localparam int SUM_W   = 10;
   localparam int OPND_W  = 11;
   localparam int OUT_W   = 8;
   localparam int UNFIX_W = 13;

   localparam int CHROMA_OFFSET = 512;
   localparam int CHROMA_ROUND  = 2;
   localparam int CHROMA_SHIFT  = 2;

   // Coefficients in ten-thousandths.
   localparam longint COEF_Y_R_TK  = 2990;
   localparam longint COEF_Y_G_TK  = 5870;
   localparam longint COEF_Y_B_TK  = 1140;
   localparam longint COEF_CB_R_TK = -1687;
   localparam longint COEF_CB_G_TK = -3313;
   localparam longint COEF_CB_B_TK = 5000;
   localparam longint COEF_CR_R_TK = 5000;
   localparam longint COEF_CR_G_TK = -4187;
   localparam longint COEF_CR_B_TK = -813;

   // Fixed-point coefficient, truncated toward zero.
   function automatic longint fix_coef(input longint tenk, input int frac_bits);
      longint mag;
      longint quo;
      mag = ((tenk < 0) ? -tenk : tenk) << frac_bits;
      quo = mag / 10000;
      return (tenk < 0) ? -quo : quo;
   endfunction

   function automatic logic [OUT_W-1:0] clip8(input logic signed [UNFIX_W-1:0] v);
      logic [OUT_W-1:0] res;
      priority if (v > $signed(UNFIX_W'(255))) begin
         res = '1;
      end else if (v < $signed(UNFIX_W'(0))) begin
         res = '0;
      end else begin
         res = v[OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> design/ycc_ifs.sv
// Valid/ready channel interfaces for pixel blocks and converted samples.
interface ycc_req_if
   import ycc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_top_left;
   logic [PIX_W-1:0] pixel_top_right;
   logic [PIX_W-1:0] pixel_bottom_left;
   logic [PIX_W-1:0] pixel_bottom_right;

   modport source (output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
                   pixel_bottom_right, input ready);
   modport sink   (input valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
                   pixel_bottom_right, output ready);
endinterface

interface ycc_rsp_if
   import ycc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] luma_top_left;
   logic [OUT_W-1:0] luma_top_right;
   logic [OUT_W-1:0] luma_bottom_left;
   logic [OUT_W-1:0] luma_bottom_right;
   logic [OUT_W-1:0] chroma_blue;
   logic [OUT_W-1:0] chroma_red;

   modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, output ready);
endinterface

>>> design/ycc_unpack_stage.sv
// Stage 1: splits pixels into components and sums each component over the block.
module ycc_unpack_stage
   import ycc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [PIX_W-1:0]  pixel [NUM_PIX],
   output logic              out_valid,
   input  logic              out_ready,
   output logic [COMP_W-1:0] comp_r [NUM_PIX],
   output logic [COMP_W-1:0] comp_g [NUM_PIX],
   output logic [COMP_W-1:0] comp_b [NUM_PIX],
   output logic [SUM_W-1:0]  sum_r,
   output logic [SUM_W-1:0]  sum_g,
   output logic [SUM_W-1:0]  sum_b
);
   logic              valid_ff;
   logic [COMP_W-1:0] comp_r_ff [NUM_PIX];
   logic [COMP_W-1:0] comp_g_ff [NUM_PIX];
   logic [COMP_W-1:0] comp_b_ff [NUM_PIX];
   logic [COMP_W-1:0] comp_r_in [NUM_PIX];
   logic [COMP_W-1:0] comp_g_in [NUM_PIX];
   logic [COMP_W-1:0] comp_b_in [NUM_PIX];
   logic [SUM_W-1:0]  sum_r_ff, sum_g_ff, sum_b_ff;
   logic [SUM_W-1:0]  sum_r_in, sum_g_in, sum_b_in;
   logic              load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      sum_r_in = '0;
      sum_g_in = '0;
      sum_b_in = '0;
      for (int k = 0; k < NUM_PIX; k++) begin
         comp_r_in[k] = pixel[k][COMP_W-1:0];
         comp_g_in[k] = pixel[k][2*COMP_W-1:COMP_W];
         comp_b_in[k] = pixel[k][3*COMP_W-1:2*COMP_W];
         sum_r_in     = sum_r_in + SUM_W'(comp_r_in[k]);
         sum_g_in     = sum_g_in + SUM_W'(comp_g_in[k]);
         sum_b_in     = sum_b_in + SUM_W'(comp_b_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         comp_r_ff <= comp_r_in;
         comp_g_ff <= comp_g_in;
         comp_b_ff <= comp_b_in;
         sum_r_ff  <= sum_r_in;
         sum_g_ff  <= sum_g_in;
         sum_b_ff  <= sum_b_in;
      end
   end

   assign out_valid = valid_ff;
   assign comp_r    = comp_r_ff;
   assign comp_g    = comp_g_ff;
   assign comp_b    = comp_b_ff;
   assign sum_r     = sum_r_ff;
   assign sum_g     = sum_g_ff;
   assign sum_b     = sum_b_ff;
endmodule

>>> design/ycc_mult_stage.sv
// Stage 2: multiplies pixel components and block sums by the fixed-point coefficients.
module ycc_mult_stage
   import ycc_pkg::*;
#(
   parameter int FRAC_BITS = FRACTION_BITS_DEF,
   parameter int PROD_W    = FRAC_BITS + OPND_W + 1
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [COMP_W-1:0]        comp_r [NUM_PIX],
   input  logic [COMP_W-1:0]        comp_g [NUM_PIX],
   input  logic [COMP_W-1:0]        comp_b [NUM_PIX],
   input  logic [SUM_W-1:0]         sum_r,
   input  logic [SUM_W-1:0]         sum_g,
   input  logic [SUM_W-1:0]         sum_b,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [PROD_W-1:0] prod_luma [NUM_PIX][NUM_CH],
   output logic signed [PROD_W-1:0] prod_cb [NUM_CH],
   output logic signed [PROD_W-1:0] prod_cr [NUM_CH]
);
   localparam int COEF_W = FRAC_BITS + 1;

   localparam logic signed [COEF_W-1:0] COEF_Y [NUM_CH] = '{
      COEF_W'(fix_coef(COEF_Y_R_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_Y_G_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_Y_B_TK, FRAC_BITS))};
   localparam logic signed [COEF_W-1:0] COEF_CB [NUM_CH] = '{
      COEF_W'(fix_coef(COEF_CB_R_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_CB_G_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_CB_B_TK, FRAC_BITS))};
   localparam logic signed [COEF_W-1:0] COEF_CR [NUM_CH] = '{
      COEF_W'(fix_coef(COEF_CR_R_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_CR_G_TK, FRAC_BITS)),
      COEF_W'(fix_coef(COEF_CR_B_TK, FRAC_BITS))};

   logic                     valid_ff;
   logic                     load;
   logic signed [OPND_W-1:0] opnd_pix [NUM_PIX][NUM_CH];
   logic signed [OPND_W-1:0] opnd_sum [NUM_CH];
   logic signed [PROD_W-1:0] prod_luma_in [NUM_PIX][NUM_CH];
   logic signed [PROD_W-1:0] prod_cb_in [NUM_CH];
   logic signed [PROD_W-1:0] prod_cr_in [NUM_CH];
   logic signed [PROD_W-1:0] prod_luma_ff [NUM_PIX][NUM_CH];
   logic signed [PROD_W-1:0] prod_cb_ff [NUM_CH];
   logic signed [PROD_W-1:0] prod_cr_ff [NUM_CH];

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      opnd_sum[CH_R] = $signed({(OPND_W-SUM_W)'(0), sum_r});
      opnd_sum[CH_G] = $signed({(OPND_W-SUM_W)'(0), sum_g});
      opnd_sum[CH_B] = $signed({(OPND_W-SUM_W)'(0), sum_b});
      for (int k = 0; k < NUM_PIX; k++) begin
         opnd_pix[k][CH_R] = $signed({(OPND_W-COMP_W)'(0), comp_r[k]});
         opnd_pix[k][CH_G] = $signed({(OPND_W-COMP_W)'(0), comp_g[k]});
         opnd_pix[k][CH_B] = $signed({(OPND_W-COMP_W)'(0), comp_b[k]});
      end
      for (int c = 0; c < NUM_CH; c++) begin
         prod_cb_in[c] = opnd_sum[c] * COEF_CB[c];
         prod_cr_in[c] = opnd_sum[c] * COEF_CR[c];
         for (int k = 0; k < NUM_PIX; k++) begin
            prod_luma_in[k][c] = opnd_pix[k][c] * COEF_Y[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_luma_ff <= prod_luma_in;
         prod_cb_ff   <= prod_cb_in;
         prod_cr_ff   <= prod_cr_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_luma = prod_luma_ff;
   assign prod_cb   = prod_cb_ff;
   assign prod_cr   = prod_cr_ff;
endmodule

>>> design/ycc_round_stage.sv
// Stage 3: sums the products, rounds half up, drops the fraction and clips luma.
module ycc_round_stage
   import ycc_pkg::*;
#(
   parameter int FRAC_BITS = FRACTION_BITS_DEF,
   parameter int PROD_W    = FRAC_BITS + OPND_W + 1
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [PROD_W-1:0]  prod_luma [NUM_PIX][NUM_CH],
   input  logic signed [PROD_W-1:0]  prod_cb [NUM_CH],
   input  logic signed [PROD_W-1:0]  prod_cr [NUM_CH],
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [OUT_W-1:0]          luma [NUM_PIX],
   output logic signed [UNFIX_W-1:0] cb_unfixed,
   output logic signed [UNFIX_W-1:0] cr_unfixed
);
   localparam int ACC_W = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic                      valid_ff;
   logic                      load;
   logic signed [ACC_W-1:0]   acc_luma [NUM_PIX];
   logic signed [ACC_W-1:0]   sh_luma [NUM_PIX];
   logic signed [ACC_W-1:0]   acc_cb, acc_cr, sh_cb, sh_cr;
   logic [OUT_W-1:0]          luma_in [NUM_PIX];
   logic [OUT_W-1:0]          luma_ff [NUM_PIX];
   logic signed [UNFIX_W-1:0] cb_ff, cr_ff, cb_in, cr_in;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // The arithmetic shift floors, which matches rounding toward minus infinity.
   always_comb begin
      acc_cb = HALF;
      acc_cr = HALF;
      for (int c = 0; c < NUM_CH; c++) begin
         acc_cb = acc_cb + ACC_W'(prod_cb[c]);
         acc_cr = acc_cr + ACC_W'(prod_cr[c]);
      end
      sh_cb = acc_cb >>> FRAC_BITS;
      sh_cr = acc_cr >>> FRAC_BITS;
      cb_in = sh_cb[UNFIX_W-1:0];
      cr_in = sh_cr[UNFIX_W-1:0];
      for (int k = 0; k < NUM_PIX; k++) begin
         acc_luma[k] = HALF;
         for (int c = 0; c < NUM_CH; c++) begin
            acc_luma[k] = acc_luma[k] + ACC_W'(prod_luma[k][c]);
         end
         sh_luma[k] = acc_luma[k] >>> FRAC_BITS;
         luma_in[k] = clip8(sh_luma[k][UNFIX_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff <= luma_in;
         cb_ff   <= cb_in;
         cr_ff   <= cr_in;
      end
   end

   assign out_valid  = valid_ff;
   assign luma       = luma_ff;
   assign cb_unfixed = cb_ff;
   assign cr_unfixed = cr_ff;
endmodule

>>> design/ycc_out_stage.sv
// Stage 4: applies the chroma offset and quarter scaling, clips, and holds the result.
module ycc_out_stage
   import ycc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [OUT_W-1:0]          luma [NUM_PIX],
   input  logic signed [UNFIX_W-1:0] cb_unfixed,
   input  logic signed [UNFIX_W-1:0] cr_unfixed,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [OUT_W-1:0]          luma_out [NUM_PIX],
   output logic [OUT_W-1:0]          cb_out,
   output logic [OUT_W-1:0]          cr_out
);
   localparam logic signed [UNFIX_W-1:0] BIAS = UNFIX_W'(CHROMA_OFFSET + CHROMA_ROUND);

   logic                      valid_ff;
   logic                      load;
   logic signed [UNFIX_W-1:0] cb_biased, cr_biased;
   logic [OUT_W-1:0]          luma_ff [NUM_PIX];
   logic [OUT_W-1:0]          cb_ff, cr_ff, cb_in, cr_in;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      cb_biased = (cb_unfixed + BIAS) >>> CHROMA_SHIFT;
      cr_biased = (cr_unfixed + BIAS) >>> CHROMA_SHIFT;
      cb_in     = clip8(cb_biased);
      cr_in     = clip8(cr_biased);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff <= luma;
         cb_ff   <= cb_in;
         cr_ff   <= cr_in;
      end
   end

   assign out_valid = valid_ff;
   assign luma_out  = luma_ff;
   assign cb_out    = cb_ff;
   assign cr_out    = cr_ff;
endmodule

>>> design/rgb_to_ycbcr420_block_unit.sv
// Top level of the 2x2 block RGB to YCbCr 4:2:0 converter.
//
//   Port     Dir  Handshake     Carries
//   req_bus  in   valid/ready   four 24-bit RGB pixels of one 2x2 block
//   rsp_bus  out  valid/ready   four luma samples, one Cb and one Cr
//
// Four register stages: unpack and sum, multiply, round and shift, chroma scale.
// One block enters per cycle while req_bus.ready is high; each block moves through the
// stage registers in order, and its result is offered on rsp_bus from the last of them.
// Reset clears the stage valid bits only; the data registers are left as they are.
// Each stage holds its item while the next one is full and stalled; empty stages
// keep accepting, so bubbles close up under a stalled output.
module rgb_to_ycbcr420_block_unit
   import ycc_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
   input  logic      clock,
   input  logic      reset,
   ycc_req_if.sink   req_bus,
   ycc_rsp_if.source rsp_bus
);
   localparam int PROD_W = FRACTION_BITS + OPND_W + 1;

   logic [PIX_W-1:0]          pixel [NUM_PIX];
   logic                      s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
   logic [COMP_W-1:0]         comp_r [NUM_PIX];
   logic [COMP_W-1:0]         comp_g [NUM_PIX];
   logic [COMP_W-1:0]         comp_b [NUM_PIX];
   logic [SUM_W-1:0]          sum_r, sum_g, sum_b;
   logic signed [PROD_W-1:0]  prod_luma [NUM_PIX][NUM_CH];
   logic signed [PROD_W-1:0]  prod_cb [NUM_CH];
   logic signed [PROD_W-1:0]  prod_cr [NUM_CH];
   logic [OUT_W-1:0]          luma [NUM_PIX];
   logic signed [UNFIX_W-1:0] cb_unfixed, cr_unfixed;
   logic [OUT_W-1:0]          luma_out [NUM_PIX];

   assign pixel[0] = req_bus.pixel_top_left;
   assign pixel[1] = req_bus.pixel_top_right;
   assign pixel[2] = req_bus.pixel_bottom_left;
   assign pixel[3] = req_bus.pixel_bottom_right;

   ycc_unpack_stage u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .pixel     (pixel),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .comp_r    (comp_r),
      .comp_g    (comp_g),
      .comp_b    (comp_b),
      .sum_r     (sum_r),
      .sum_g     (sum_g),
      .sum_b     (sum_b)
   );

   ycc_mult_stage #(
      .FRAC_BITS (FRACTION_BITS),
      .PROD_W    (PROD_W)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .comp_r    (comp_r),
      .comp_g    (comp_g),
      .comp_b    (comp_b),
      .sum_r     (sum_r),
      .sum_g     (sum_g),
      .sum_b     (sum_b),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .prod_luma (prod_luma),
      .prod_cb   (prod_cb),
      .prod_cr   (prod_cr)
   );

   ycc_round_stage #(
      .FRAC_BITS (FRACTION_BITS),
      .PROD_W    (PROD_W)
   ) u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .prod_luma  (prod_luma),
      .prod_cb    (prod_cb),
      .prod_cr    (prod_cr),
      .out_valid  (s3_valid),
      .out_ready  (s3_ready),
      .luma       (luma),
      .cb_unfixed (cb_unfixed),
      .cr_unfixed (cr_unfixed)
   );

   ycc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid),
      .in_ready   (s3_ready),
      .luma       (luma),
      .cb_unfixed (cb_unfixed),
      .cr_unfixed (cr_unfixed),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .luma_out   (luma_out),
      .cb_out     (rsp_bus.chroma_blue),
      .cr_out     (rsp_bus.chroma_red)
   );

   assign rsp_bus.luma_top_left     = luma_out[0];
   assign rsp_bus.luma_top_right    = luma_out[1];
   assign rsp_bus.luma_bottom_left  = luma_out[2];
   assign rsp_bus.luma_bottom_right = luma_out[3];
endmodule

>>> design/ycc_checker.sv
// Port-level checker for the block converter and its bind to the top level.
`include "assert_macros.svh"

module ycc_checker
   import ycc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] luma_top_left,
   input logic [OUT_W-1:0] luma_top_right,
   input logic [OUT_W-1:0] luma_bottom_left,
   input logic [OUT_W-1:0] luma_bottom_right,
   input logic [OUT_W-1:0] chroma_blue,
   input logic [OUT_W-1:0] chroma_red
);
   logic               req_take;
   logic [6*OUT_W-1:0] rsp_fields;

   assign req_take   = req_valid && req_ready;
   assign rsp_fields = {luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
                        chroma_blue, chroma_red};

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps all of its samples.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_fields))

   // With the output drained every cycle the pipeline never pushes back.
   `ASSERT_IMPLY(a_no_backpressure, clock, reset, rsp_ready, req_ready)

   // Reset empties the pipeline, so no stale result is offered afterwards.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // With the output drained, a taken item passes through every stage and is offered.
   `ASSERT_NEXT(a_latency, clock, reset, req_take ##1 rsp_ready [*3], rsp_valid)
endmodule

bind rgb_to_ycbcr420_block_unit ycc_checker u_ycc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .luma_top_left     (rsp_bus.luma_top_left),
   .luma_top_right    (rsp_bus.luma_top_right),
   .luma_bottom_left  (rsp_bus.luma_bottom_left),
   .luma_bottom_right (rsp_bus.luma_bottom_right),
   .chroma_blue       (rsp_bus.chroma_blue),
   .chroma_red        (rsp_bus.chroma_red)
);
